>>> design/lr_pkg.sv
// shared constants for the line rasterizer
`default_nettype none
package lr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DIM_BITS       = 11;
    localparam int COLOR_BITS     = 16;
    localparam int REG_IDX_BITS   = 1;

    localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = DIM_BITS'(128);
    localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(160);

    // operation codes carried in s_tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // configuration register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = REG_IDX_BITS'(1);

endpackage
`default_nettype wire

>>> design/lr_setup.sv
// line setup: steep test, endpoint ordering, deltas and initial error
`default_nettype none
module lr_setup #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              steep,
    output logic signed [COORD_BITS-1:0]      major_start,
    output logic signed [COORD_BITS-1:0]      major_end,
    output logic signed [COORD_BITS-1:0]      minor_start,
    output logic        [COORD_BITS:0]        major_delta,
    output logic        [COORD_BITS:0]        minor_delta,
    output logic signed [COORD_BITS+1:0]      error_init,
    output logic                              step_down
);

    localparam int C = COORD_BITS;

    function automatic logic [C:0] abs_diff(input logic signed [C-1:0] a,
                                            input logic signed [C-1:0] b);
        logic signed [C:0] d;
        d = $signed({a[C-1], a}) - $signed({b[C-1], b});
        abs_diff = d[C] ? -d : d;
    endfunction

    logic [C:0] adx;
    logic [C:0] ady;
    logic signed [C-1:0] ax;
    logic signed [C-1:0] ay;
    logic signed [C-1:0] bx;
    logic signed [C-1:0] by;
    logic signed [C-1:0] lx;
    logic signed [C-1:0] ly;
    logic signed [C-1:0] rx;
    logic signed [C-1:0] ry;

    always_comb
    begin
        adx   = abs_diff(start_x, end_x);
        ady   = abs_diff(start_y, end_y);
        steep = ady > adx;
        ax    = steep ? start_y : start_x;
        ay    = steep ? start_x : start_y;
        bx    = steep ? end_y   : end_x;
        by    = steep ? end_x   : end_y;
        if (ax > bx)
        begin
            lx = bx;
            ly = by;
            rx = ax;
            ry = ay;
        end
        else
        begin
            lx = ax;
            ly = ay;
            rx = bx;
            ry = by;
        end
        major_start = lx;
        major_end   = rx;
        minor_start = ly;
        major_delta = {rx[C-1], rx} - {lx[C-1], lx};
        minor_delta = abs_diff(ly, ry);
        error_init  = $signed({2'b00, major_delta[C:1]});
        step_down   = !(ly < ry);
    end

endmodule
`default_nettype wire

>>> design/line_rasterizer.sv
// line_rasterizer: Bresenham line rasterizer, one pixel per step beat
//
// input stream: s_tuser selects the operation (load a new line or step);
// s_tdata carries start_x, start_y, end_x, end_y and line_color, used on load.
// a load beat gives no output and replaces any line in progress. a step beat
// while a line is active gives one output beat: pixel_x, pixel_y and
// pixel_color in m_tdata, on_screen in m_tuser, last_pixel in m_tlast. a step
// beat while idle gives nothing.
// screen_width and screen_height are written through cfg_we/cfg_addr/cfg_wdata
// and only bound the on_screen test.
// an input beat is registered, then the step is worked out and the pixel lands
// in the output register. throughput is one beat per cycle while the receiver
// does not stall, set by the error add-compare-update on the line state.
// when the receiver stalls the output register holds and the input register
// takes one more step beat before s_tready drops; loads and idle steps still pass.
// reset clears all valids and the active line and loads the default screen
// size of 128 by 160.
`default_nettype none
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // start_x, start_y, end_x, end_y, line_color, zero fill
    input  wire logic [((4*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  wire logic                                          s_tuser,
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic [((2*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
    // on_screen
    output logic                                               m_tuser,
    output logic                                               m_tlast,
    input  wire logic                                          cfg_we,
    input  wire logic [lr_pkg::REG_IDX_BITS-1:0]               cfg_addr,
    input  wire logic [lr_pkg::DIM_BITS-1:0]                   cfg_wdata
);

    localparam int C        = COORD_BITS;
    localparam int CB       = lr_pkg::COLOR_BITS;
    localparam int DB       = lr_pkg::DIM_BITS;
    localparam int IN_BITS  = 4*C + CB;
    localparam int OUT_BITS = 2*C + CB;
    localparam int OUT_W    = ((OUT_BITS+7)/8)*8;
    localparam int CMP_BITS = C + DB;

    logic               in_valid_reg;
    logic               in_op_reg;
    logic [IN_BITS-1:0] in_data_reg;

    logic [DB-1:0] width_reg;
    logic [DB-1:0] height_reg;

    logic                 active_reg;
    logic                 active_next;
    logic                 steep_reg;
    logic                 steep_next;
    logic signed [C-1:0]  major_pos_reg;
    logic signed [C-1:0]  major_pos_next;
    logic signed [C-1:0]  major_end_reg;
    logic signed [C-1:0]  major_end_next;
    logic signed [C-1:0]  minor_pos_reg;
    logic signed [C-1:0]  minor_pos_next;
    logic [C:0]           major_delta_reg;
    logic [C:0]           major_delta_next;
    logic [C:0]           minor_delta_reg;
    logic [C:0]           minor_delta_next;
    logic signed [C+1:0]  error_reg;
    logic signed [C+1:0]  error_next;
    logic                 down_reg;
    logic                 down_next;
    logic [CB-1:0]        color_reg;
    logic [CB-1:0]        color_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [C-1:0]  out_x_reg;
    logic [C-1:0]  out_y_reg;
    logic [CB-1:0] out_color_reg;
    logic          out_vis_reg;
    logic          out_last_reg;

    logic                 su_steep;
    logic signed [C-1:0]  su_major_start;
    logic signed [C-1:0]  su_major_end;
    logic signed [C-1:0]  su_minor_start;
    logic [C:0]           su_major_delta;
    logic [C:0]           su_minor_delta;
    logic signed [C+1:0]  su_error;
    logic                 su_down;

    logic                 out_free;
    logic                 proc;
    logic                 emit;
    logic [C-1:0]         px;
    logic [C-1:0]         py;
    logic                 last;
    logic                 vis;
    logic signed [C+1:0]  err_sub;

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x     (in_data_reg[C-1:0]),
        .start_y     (in_data_reg[2*C-1:C]),
        .end_x       (in_data_reg[3*C-1:2*C]),
        .end_y       (in_data_reg[4*C-1:3*C]),
        .steep       (su_steep),
        .major_start (su_major_start),
        .major_end   (su_major_end),
        .minor_start (su_minor_start),
        .major_delta (su_major_delta),
        .minor_delta (su_minor_delta),
        .error_init  (su_error),
        .step_down   (su_down)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && (in_op_reg == lr_pkg::OP_LOAD || !active_reg || out_free);
    assign emit     = proc && in_op_reg == lr_pkg::OP_STEP && active_reg;
    assign s_tready = !in_valid_reg || proc;

    always_comb
    begin
        px      = steep_reg ? minor_pos_reg : major_pos_reg;
        py      = steep_reg ? major_pos_reg : minor_pos_reg;
        last    = major_pos_reg == major_end_reg;
        vis     = !px[C-1] && !py[C-1]
                  && CMP_BITS'(px) < CMP_BITS'(width_reg)
                  && CMP_BITS'(py) < CMP_BITS'(height_reg);
        err_sub = error_reg - $signed({1'b0, minor_delta_reg});

        active_next      = active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        error_next       = error_reg;
        down_next        = down_reg;
        color_next       = color_reg;

        if (proc && in_op_reg == lr_pkg::OP_LOAD)
        begin
            active_next      = 1'b1;
            steep_next       = su_steep;
            major_pos_next   = su_major_start;
            major_end_next   = su_major_end;
            minor_pos_next   = su_minor_start;
            major_delta_next = su_major_delta;
            minor_delta_next = su_minor_delta;
            error_next       = su_error;
            down_next        = su_down;
            color_next       = in_data_reg[IN_BITS-1:4*C];
        end
        else if (emit)
        begin
            error_next = err_sub;
            if (err_sub < 0)
            begin
                minor_pos_next = down_reg ? minor_pos_reg - C'(1) : minor_pos_reg + C'(1);
                error_next     = err_sub + $signed({1'b0, major_delta_reg});
            end
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + C'(1);
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            width_reg     <= lr_pkg::SCREEN_WIDTH_RESET;
            height_reg    <= lr_pkg::SCREEN_HEIGHT_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    lr_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                    lr_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
        steep_reg       <= steep_next;
        major_pos_reg   <= major_pos_next;
        major_end_reg   <= major_end_next;
        minor_pos_reg   <= minor_pos_next;
        major_delta_reg <= major_delta_next;
        minor_delta_reg <= minor_delta_next;
        error_reg       <= error_next;
        down_reg        <= down_next;
        color_reg       <= color_next;
        if (emit)
        begin
            out_x_reg     <= px;
            out_y_reg     <= py;
            out_color_reg <= color_reg;
            out_vis_reg   <= vis;
            out_last_reg  <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_color_reg, out_y_reg, out_x_reg});
    assign m_tuser  = out_vis_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

>>> design/lr_checker.sv
// port checker for the line rasterizer and its bind
`default_nettype none
module lr_checker #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input wire logic                                                   clk,
    input wire logic                                                   rst_n,
    input wire logic                                                   s_tready,
    input wire logic                                                   m_tvalid,
    input wire logic                                                   m_tready,
    input wire logic [((2*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0]   m_tdata,
    input wire logic                                                   m_tuser,
    input wire logic                                                   m_tlast
);

    localparam int C = COORD_BITS;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // input only backs up behind a stalled output
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // no output beat right after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("output beat right after reset");

    // visible pixel has nonnegative coordinates
    a_vis_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[C-1] && !m_tdata[2*C-1])
        else $error("on_screen pixel with negative coordinate");

endmodule

bind line_rasterizer lr_checker #(
    .COORD_BITS (COORD_BITS)
) u_lr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
